FILE: hw/rtl/pfr_pkg.sv
// Shared types, codes and tables for the page framebuffer refresh block.
// No dependencies; imported by every module of the block.
package pfr_pkg;

    // Default screen geometry (top-level parameter defaults)
    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;

    // Frame store: 8 pages of 128 column bytes
    localparam int COLS_PER_PAGE = 128;
    localparam int MAX_PAGES     = 8;
    localparam int MEM_DEPTH     = COLS_PER_PAGE * MAX_PAGES;
    localparam int MEM_ADDR_W    = $clog2(MEM_DEPTH);

    // Request kinds
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_REFRESH = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PARTIAL    = 1'b0;
    localparam logic CFG_COL_OFFSET = 1'b1;

    // Display controller commands
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW  = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [7:0] CMD_RMW      = 8'hE0;

    // Page remap: logical page to controller page
    function automatic logic [2:0] page_remap(input logic [2:0] page);
        logic [2:0] r;
        unique case (page)
            3'd0: r = 3'd3;
            3'd1: r = 3'd2;
            3'd2: r = 3'd1;
            3'd3: r = 3'd0;
            3'd4: r = 3'd7;
            3'd5: r = 3'd6;
            3'd6: r = 3'd5;
            3'd7: r = 3'd4;
        endcase
        return r;
    endfunction

    // Execute-cycle request to the refresh sequencer
    typedef struct packed {
        logic       step;   // refresh step request
        logic       wr;     // in-range pixel write, widens dirty box
        logic [6:0] wx;
        logic [5:0] wy;
    } step_req_t;

    // Byte produced by a refresh step
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       valid;
        logic       last;
    } step_rsp_t;

endpackage

FILE: hw/rtl/page_framebuffer_refresh.sv
// Top level of the page framebuffer refresh block: request control, clear pass,
// pixel read-modify-write and result registers. Depends on pfr_pkg, pfr_ram, pfr_refresh.
//
//  Channel   | Handshake                     | Payload
//  ----------+-------------------------------+---------------------------------------------
//  request   | start, busy (taken: start&~busy) | kind, x, y, color
//  result    | done (one-cycle strobe)       | pixel_value, out_byte, is_data, byte_valid,
//            |                               | frame_last
//  config    | cfg_we                        | cfg_index, cfg_data
//
// Each request passes through S_EXEC: the frame store read is issued at the accepting
// edge, S_EXEC computes, writes back and loads the result registers, and
// done is high in the cycle after that, back in S_IDLE. The single RAM port pair sets this order.
// A new request may be accepted in the same cycle that done is high.
// After reset a clearing pass writes all 1024 store bytes to zero, one per cycle;
// busy is high throughout the pass. Config writes are taken at any time.
// The result side cannot stall: each result is shown for exactly one cycle.
module page_framebuffer_refresh #(
    parameter int SCREEN_WIDTH  = pfr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfr_pkg::DEF_SCREEN_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    // request
    input  logic       start,
    output logic       busy,
    input  logic [1:0] kind,
    input  logic [7:0] x,
    input  logic [7:0] y,
    input  logic       color,
    // result
    output logic       done,
    output logic       pixel_value,
    output logic [7:0] out_byte,
    output logic       is_data,
    output logic       byte_valid,
    output logic       frame_last,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);
    import pfr_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;

    logic [MEM_ADDR_W-1:0] clr_cnt_reg;
    logic [1:0]            kind_reg;
    logic [7:0]            x_reg;
    logic [7:0]            y_reg;
    logic                  color_reg;
    logic                  partial_enable_reg;
    logic [6:0]            column_offset_reg;

    logic                  done_reg;
    logic                  pixel_value_reg;
    logic [7:0]            out_byte_reg;
    logic                  is_data_reg;
    logic                  byte_valid_reg;
    logic                  frame_last_reg;

    logic                  accept;
    logic                  in_range;
    logic                  exec;
    logic [MEM_ADDR_W-1:0] pix_addr;
    logic [MEM_ADDR_W-1:0] raddr;
    logic [MEM_ADDR_W-1:0] cur_addr;
    logic [7:0]            rd_data;
    logic [2:0]            bit_idx;
    logic                  cur_pixel;
    logic [7:0]            mod_byte;
    logic                  pix_wr;
    logic                  ram_we;
    logic [MEM_ADDR_W-1:0] ram_waddr;
    logic [7:0]            ram_wdata;
    step_req_t             step_req;
    step_rsp_t             step_rsp;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && (state_reg == S_IDLE);
    assign exec   = (state_reg == S_EXEC);

    // read address chosen at accept: cursor byte for refresh, pixel byte otherwise
    assign raddr = (kind == KIND_REFRESH) ? cur_addr : {y[5:3], x[6:0]};

    // execute cycle: latched request, read data now valid
    assign in_range  = (x_reg < 8'(SCREEN_WIDTH)) && (y_reg < 8'(SCREEN_HEIGHT));
    assign pix_addr  = {y_reg[5:3], x_reg[6:0]};
    assign bit_idx   = 3'd7 - y_reg[2:0];
    assign cur_pixel = rd_data[bit_idx];

    always_comb
    begin
        mod_byte          = rd_data;
        mod_byte[bit_idx] = color_reg;
    end

    assign pix_wr    = exec && (kind_reg == KIND_WRITE) && in_range;
    assign ram_we    = (state_reg == S_CLEAR) || pix_wr;
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : pix_addr;
    assign ram_wdata = (state_reg == S_CLEAR) ? 8'd0 : mod_byte;

    assign step_req.step = exec && (kind_reg == KIND_REFRESH);
    assign step_req.wr   = pix_wr;
    assign step_req.wx   = x_reg[6:0];
    assign step_req.wy   = y_reg[5:0];

    pfr_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (raddr),
        .rdata (rd_data)
    );

    pfr_refresh #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_refresh (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (step_req),
        .partial_enable (partial_enable_reg),
        .column_offset  (column_offset_reg),
        .rd_data        (rd_data),
        .cur_addr       (cur_addr),
        .rsp            (step_rsp)
    );

    // control FSM and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            kind_reg        <= KIND_WRITE;
            x_reg           <= 8'd0;
            y_reg           <= 8'd0;
            color_reg       <= 1'b0;
            done_reg        <= 1'b0;
            pixel_value_reg <= 1'b0;
            out_byte_reg    <= 8'd0;
            is_data_reg     <= 1'b0;
            byte_valid_reg  <= 1'b0;
            frame_last_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == MEM_ADDR_W'(MEM_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= kind;
                        x_reg     <= x;
                        y_reg     <= y;
                        color_reg <= color;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    done_reg        <= 1'b1;
                    pixel_value_reg <= (kind_reg == KIND_READ) && in_range && cur_pixel;
                    out_byte_reg    <= step_rsp.out_byte;
                    is_data_reg     <= step_rsp.is_data;
                    byte_valid_reg  <= step_rsp.valid;
                    frame_last_reg  <= step_rsp.last;
                    state_reg       <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_enable_reg <= 1'b0;
            column_offset_reg  <= 7'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PARTIAL:    partial_enable_reg <= cfg_data[0];
                CFG_COL_OFFSET: column_offset_reg  <= cfg_data;
            endcase
        end
    end

    assign done        = done_reg;
    assign pixel_value = pixel_value_reg;
    assign out_byte    = out_byte_reg;
    assign is_data     = is_data_reg;
    assign byte_valid  = byte_valid_reg;
    assign frame_last  = frame_last_reg;

    // a result only follows an execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without execute cycle");

    // an accepted request goes straight to execute
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted request did not execute");

    // no pixel store write, refresh step or result while clearing
    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!pix_wr && !step_req.step && !done))
        else $error("request activity during clearing pass");

    // a data byte shown with a result is always a valid byte
    a_data_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_data) |-> byte_valid)
        else $error("data flag without valid byte");

endmodule

FILE: hw/rtl/pfr_ram.sv
// Frame store RAM: one write port, one read port, registered read data.
// Depends on pfr_pkg for depth and address width.
module pfr_ram
(
    input  logic                           clk,
    input  logic                           we,
    input  logic [pfr_pkg::MEM_ADDR_W-1:0] waddr,
    input  logic [7:0]                     wdata,
    input  logic                           re,
    input  logic [pfr_pkg::MEM_ADDR_W-1:0] raddr,
    output logic [7:0]                     rdata
);
    import pfr_pkg::*;

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/pfr_refresh.sv
// Refresh sequencer: dirty box tracking, frame box latch, page/phase/column cursors.
// Depends on pfr_pkg (step_req_t, step_rsp_t, commands, page remap).
module pfr_refresh #(
    parameter int SCREEN_WIDTH  = pfr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfr_pkg::DEF_SCREEN_HEIGHT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfr_pkg::step_req_t             req,
    input  logic                           partial_enable,
    input  logic [6:0]                     column_offset,
    input  logic [7:0]                     rd_data,
    output logic [pfr_pkg::MEM_ADDR_W-1:0] cur_addr,
    output pfr_pkg::step_rsp_t             rsp
);
    import pfr_pkg::*;

    localparam int         PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam logic [6:0] X_MAX      = 7'(SCREEN_WIDTH - 1);
    localparam logic [5:0] Y_MAX      = 6'(SCREEN_HEIGHT - 1);

    localparam logic [2:0] PH_PAGE   = 3'd0;
    localparam logic [2:0] PH_COL_LO = 3'd1;
    localparam logic [2:0] PH_COL_HI = 3'd2;
    localparam logic [2:0] PH_RMW    = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;

    // lowest set bit: {found, index}
    function automatic logic [3:0] first_set(input logic [7:0] v);
        logic [3:0] r;
        r = '0;
        for (int p = 7; p >= 0; p--)
        begin
            if (v[p])
            begin
                r = {1'b1, 3'(p)};
            end
        end
        return r;
    endfunction

    logic       active_reg, active_next;
    logic [2:0] page_reg, page_next;
    logic [2:0] phase_reg, phase_next;
    logic [6:0] col_reg, col_next;
    logic [6:0] bx_lo_reg, bx_lo_next, bx_hi_reg, bx_hi_next;
    logic [5:0] by_lo_reg, by_lo_next, by_hi_reg, by_hi_next;
    logic [6:0] dx_lo_reg, dx_lo_next, dx_hi_reg, dx_hi_next;
    logic [5:0] dy_lo_reg, dy_lo_next, dy_hi_reg, dy_hi_next;

    logic [6:0] src_xlo, src_xhi, eff_xlo, eff_xhi;
    logic [5:0] src_ylo, src_yhi, eff_ylo, eff_yhi;
    logic [7:0] cov, later_mask;
    logic [3:0] first_any, first_later;
    logic [7:0] addr;

    assign cur_addr = {page_reg, col_reg};

    // box used at frame start: dirty box or whole screen
    assign src_xlo = partial_enable ? dx_lo_reg : 7'd0;
    assign src_xhi = partial_enable ? dx_hi_reg : X_MAX;
    assign src_ylo = partial_enable ? dy_lo_reg : 6'd0;
    assign src_yhi = partial_enable ? dy_hi_reg : Y_MAX;

    assign eff_xlo = active_reg ? bx_lo_reg : src_xlo;
    assign eff_xhi = active_reg ? bx_hi_reg : src_xhi;
    assign eff_ylo = active_reg ? by_lo_reg : src_ylo;
    assign eff_yhi = active_reg ? by_hi_reg : src_yhi;

    always_comb
    begin
        for (int p = 0; p < 8; p++)
        begin
            cov[p] = ({1'b0, eff_ylo} < 7'((p + 1) * 8)) && (eff_yhi >= 6'(p * 8))
                     && (p < PAGE_COUNT);
        end
    end

    assign later_mask  = ~((8'd2 << page_reg) - 8'd1);
    assign first_any   = first_set(cov);
    assign first_later = first_set(cov & later_mask);
    assign addr        = {1'b0, eff_xlo} + {1'b0, column_offset};

    always_comb
    begin
        logic       go;
        logic       advance;
        logic [2:0] pg;
        logic [2:0] ph;

        active_next = active_reg;
        page_next   = page_reg;
        phase_next  = phase_reg;
        col_next    = col_reg;
        bx_lo_next  = bx_lo_reg;
        bx_hi_next  = bx_hi_reg;
        by_lo_next  = by_lo_reg;
        by_hi_next  = by_hi_reg;
        dx_lo_next  = dx_lo_reg;
        dx_hi_next  = dx_hi_reg;
        dy_lo_next  = dy_lo_reg;
        dy_hi_next  = dy_hi_reg;
        rsp         = '0;
        go          = 1'b0;
        advance     = 1'b0;
        pg          = page_reg;
        ph          = phase_reg;

        if (req.step)
        begin
            go = 1'b1;
            if (!active_reg)
            begin
                // frame start: latch box, empty live box
                bx_lo_next = src_xlo;
                bx_hi_next = src_xhi;
                by_lo_next = src_ylo;
                by_hi_next = src_yhi;
                dx_lo_next = X_MAX;
                dx_hi_next = 7'd0;
                dy_lo_next = Y_MAX;
                dy_hi_next = 6'd0;
                if (!first_any[3])
                begin
                    rsp.last = 1'b1;
                    go       = 1'b0;
                end
                else
                begin
                    active_next = 1'b1;
                    pg          = first_any[2:0];
                    ph          = PH_PAGE;
                    page_next   = pg;
                    col_next    = 7'd0;
                end
            end

            if (go)
            begin
                rsp.valid = 1'b1;
                unique case (ph)
                    PH_COL_LO:
                    begin
                        rsp.out_byte = CMD_COL_LOW | {4'd0, addr[3:0]};
                        phase_next   = PH_COL_HI;
                    end
                    PH_COL_HI:
                    begin
                        rsp.out_byte = CMD_COL_HIGH | {4'd0, addr[7:4]};
                        phase_next   = PH_RMW;
                    end
                    PH_RMW:
                    begin
                        rsp.out_byte = CMD_RMW;
                        if (eff_xlo <= eff_xhi)
                        begin
                            phase_next = PH_DATA;
                            col_next   = eff_xlo;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        rsp.is_data  = 1'b1;
                        rsp.out_byte = rd_data;
                        if (col_reg >= eff_xhi)
                        begin
                            advance = 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 7'd1;
                        end
                    end
                    default:
                    begin
                        rsp.out_byte = CMD_PAGE | {5'd0, page_remap(pg)};
                        phase_next   = PH_COL_LO;
                    end
                endcase

                if (advance)
                begin
                    if (!first_later[3])
                    begin
                        active_next = 1'b0;
                        page_next   = 3'd0;
                        phase_next  = PH_PAGE;
                        col_next    = 7'd0;
                        rsp.last    = 1'b1;
                    end
                    else
                    begin
                        page_next  = first_later[2:0];
                        phase_next = PH_PAGE;
                    end
                end
            end
        end

        if (req.wr)
        begin
            if (req.wx < dx_lo_reg) dx_lo_next = req.wx;
            if (req.wx > dx_hi_reg) dx_hi_next = req.wx;
            if (req.wy < dy_lo_reg) dy_lo_next = req.wy;
            if (req.wy > dy_hi_reg) dy_hi_next = req.wy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            page_reg   <= 3'd0;
            phase_reg  <= PH_PAGE;
            col_reg    <= 7'd0;
            bx_lo_reg  <= 7'd0;
            bx_hi_reg  <= 7'd0;
            by_lo_reg  <= 6'd0;
            by_hi_reg  <= 6'd0;
            dx_lo_reg  <= 7'd0;
            dx_hi_reg  <= X_MAX;
            dy_lo_reg  <= 6'd0;
            dy_hi_reg  <= Y_MAX;
        end
        else
        begin
            active_reg <= active_next;
            page_reg   <= page_next;
            phase_reg  <= phase_next;
            col_reg    <= col_next;
            bx_lo_reg  <= bx_lo_next;
            bx_hi_reg  <= bx_hi_next;
            by_lo_reg  <= by_lo_next;
            by_hi_reg  <= by_hi_next;
            dx_lo_reg  <= dx_lo_next;
            dx_hi_reg  <= dx_hi_next;
            dy_lo_reg  <= dy_lo_next;
            dy_hi_reg  <= dy_hi_next;
        end
    end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for page_framebuffer_refresh: pixel writes and reads and
// full or dirty-rectangle refresh frames, checked against a built-in predictor.
// Depends on pfr_pkg and the page_framebuffer_refresh RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfr_pkg::*;

    localparam int SCREEN_W = DEF_SCREEN_WIDTH;
    localparam int SCREEN_H = DEF_SCREEN_HEIGHT;
    localparam int PAGES    = (SCREEN_H + 7) / 8;

    // kind 3 is not decoded by the block: no effect, all-zero result
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // logical page -> controller page, three bits per entry, page 0 in the low bits
    localparam logic [23:0] PAGE_MAP = {3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};

    // where the frame sequencer is inside the current page
    typedef enum logic [2:0] {
        PH_PAGE,
        PH_COL_LO,
        PH_COL_HI,
        PH_RMW,
        PH_DATA
    } refresh_phase_t;

    // one result as the block shows it on its result ports
    typedef struct packed {
        logic       pixel_value;
        logic [7:0] out_byte;
        logic       is_data;
        logic       byte_valid;
        logic       frame_last;
    } frame_result_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] kind = KIND_WRITE;
    logic [7:0] x = '0;
    logic [7:0] y = '0;
    logic       color = 1'b0;
    logic       done;
    logic       pixel_value;
    logic [7:0] out_byte;
    logic       is_data;
    logic       byte_valid;
    logic       frame_last;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_PARTIAL;
    logic [6:0] cfg_data = '0;

    page_framebuffer_refresh dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .x           (x),
        .y           (y),
        .color       (color),
        .done        (done),
        .pixel_value (pixel_value),
        .out_byte    (out_byte),
        .is_data     (is_data),
        .byte_valid  (byte_valid),
        .frame_last  (frame_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: shadow picture, live dirty box, latched frame box,
    // frame sequencer position and the two config registers.
    // ------------------------------------------------------------------
    logic [7:0]     shadow_fb [0:1023];
    logic [6:0]     live_xlo = 7'd0;
    logic [6:0]     live_xhi = 7'(SCREEN_W - 1);
    logic [5:0]     live_ylo = 6'd0;
    logic [5:0]     live_yhi = 6'(SCREEN_H - 1);
    logic [6:0]     box_xlo = '0;
    logic [6:0]     box_xhi = '0;
    logic [5:0]     box_ylo = '0;
    logic [5:0]     box_yhi = '0;
    bit             fr_active = 1'b0;
    logic [2:0]     fr_page = '0;
    refresh_phase_t fr_phase = PH_PAGE;
    logic [6:0]     fr_col = '0;
    bit             mode_partial = 1'b0;
    logic [6:0]     col_offset = '0;

    frame_result_t expected_q [$];
    int            error_count = 0;
    int            quiet_left = 0;

    // region that area-local writes and reads land in (may spill off screen)
    int area_x = 0;
    int area_y = 0;
    int area_w = 7;
    int area_h = 7;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run (clear pass + ~1300 requests
    // with their sender gaps is about 0.35 ms).
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // First page at or above 'from' that the latched box touches, -1 if none.
    function automatic int first_page(input int from);
        for (int p = from; p < PAGES; p++)
            if (int'(box_ylo) < (p + 1) * 8 && int'(box_yhi) >= p * 8)
                return p;
        return -1;
    endfunction

    // Step to the next covered page; returns 1 when that was the last one.
    function automatic bit leave_page();
        int p;
        p = first_page(int'(fr_page) + 1);
        if (p < 0) begin
            fr_active = 1'b0;
            fr_page   = '0;
            fr_phase  = PH_PAGE;
            fr_col    = '0;
            return 1'b1;
        end
        fr_page  = 3'(p);
        fr_phase = PH_PAGE;
        return 1'b0;
    endfunction

    // Applies one accepted request to the predictor and returns its result.
    task automatic model_request(input logic [1:0] k, input logic [7:0] px,
                                 input logic [7:0] py, input logic c,
                                 output frame_result_t r);
        logic [9:0] idx;
        logic [7:0] addr;
        bit         on_screen;
        bit         go;
        int         pg;
        r         = '0;
        idx       = {py[5:3], px[6:0]};
        on_screen = (px < SCREEN_W) && (py < SCREEN_H);
        case (k)
            KIND_WRITE: begin
                if (on_screen) begin
                    shadow_fb[idx][3'd7 - py[2:0]] = c;
                    if (px[6:0] < live_xlo) live_xlo = px[6:0];
                    if (px[6:0] > live_xhi) live_xhi = px[6:0];
                    if (py[5:0] < live_ylo) live_ylo = py[5:0];
                    if (py[5:0] > live_yhi) live_yhi = py[5:0];
                end
            end
            KIND_READ: begin
                if (on_screen)
                    r.pixel_value = shadow_fb[idx][3'd7 - py[2:0]];
            end
            KIND_REFRESH: begin
                go = 1'b1;
                if (!fr_active) begin
                    // frame start: latch the box, then empty the live box
                    if (mode_partial) begin
                        box_xlo = live_xlo;
                        box_xhi = live_xhi;
                        box_ylo = live_ylo;
                        box_yhi = live_yhi;
                    end
                    else begin
                        box_xlo = 7'd0;
                        box_xhi = 7'(SCREEN_W - 1);
                        box_ylo = 6'd0;
                        box_yhi = 6'(SCREEN_H - 1);
                    end
                    live_xlo = 7'(SCREEN_W - 1);
                    live_xhi = 7'd0;
                    live_ylo = 6'(SCREEN_H - 1);
                    live_yhi = 6'd0;
                    pg = first_page(0);
                    if (pg < 0) begin
                        // nothing dirty: a lone frame_last with no byte
                        r.frame_last = 1'b1;
                        go = 1'b0;
                    end
                    else begin
                        fr_active = 1'b1;
                        fr_page   = 3'(pg);
                        fr_phase  = PH_PAGE;
                        fr_col    = '0;
                    end
                end
                if (go) begin
                    // offset is live, not latched: a mid-frame write takes effect
                    addr = 8'(box_xlo) + 8'(col_offset);
                    r.byte_valid = 1'b1;
                    case (fr_phase)
                        PH_PAGE: begin
                            r.out_byte = CMD_PAGE | {5'd0, PAGE_MAP[fr_page * 3 +: 3]};
                            fr_phase = PH_COL_LO;
                        end
                        PH_COL_LO: begin
                            r.out_byte = CMD_COL_LOW | {4'd0, addr[3:0]};
                            fr_phase = PH_COL_HI;
                        end
                        PH_COL_HI: begin
                            r.out_byte = CMD_COL_HIGH | {4'd0, addr[7:4]};
                            fr_phase = PH_RMW;
                        end
                        PH_RMW: begin
                            r.out_byte = CMD_RMW;
                            if (box_xlo <= box_xhi) begin
                                fr_phase = PH_DATA;
                                fr_col   = box_xlo;
                            end
                            else if (leave_page()) begin
                                r.frame_last = 1'b1;
                            end
                        end
                        default: begin
                            // data comes from the picture as it is right now
                            r.is_data  = 1'b1;
                            r.out_byte = shadow_fb[{fr_page, fr_col}];
                            if (fr_col >= box_xhi) begin
                                if (leave_page())
                                    r.frame_last = 1'b1;
                            end
                            else begin
                                fr_col = fr_col + 7'd1;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    // Sender gap per request, with occasional back-to-back stretches.
    function automatic int draw_gap();
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            quiet_left = $urandom_range(10, 60);
        return $urandom_range(0, 10);
    endfunction

    // Drives one request and holds it until taken (start & ~busy at a rising
    // edge). Acceptance is decided at the falling edge before, where busy and
    // start are stable. Returns at the accepting edge with start still high,
    // so a following request goes out back to back.
    task automatic send_request(input logic [1:0] k, input logic [7:0] px,
                                input logic [7:0] py, input logic c);
        int            gap;
        frame_result_t want;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind  <= k;
        x     <= px;
        y     <= py;
        color <= c;
        do
            @(negedge clk);
        while (busy !== 1'b0);
        model_request(k, px, py, c, want);
        expected_q.push_back(want);
        @(posedge clk);
    endtask

    // Drops start and waits until every request has produced its result.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_register(input logic idx, input logic [6:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PARTIAL)
            mode_partial = val[0];
        else
            col_offset = val;
    endtask

    // Random write (or read) inside the current area; may spill off screen.
    task automatic poke_area(input bit write_only);
        logic [7:0] px;
        logic [7:0] py;
        logic [1:0] k;
        px = 8'(area_x + $urandom_range(0, area_w));
        py = 8'(area_y + $urandom_range(0, area_h));
        k  = (write_only || $urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_READ;
        send_request(k, px, py, 1'($urandom_range(0, 1)));
    endtask

    // Refresh steps until the frame ends, with some pixel traffic mixed in.
    task automatic run_frame(input int mix_pct);
        do begin
            if ($urandom_range(0, 99) < mix_pct)
                poke_area(1'b0);
            send_request(KIND_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
        end while (fr_active);
    endtask

    // ------------------------------------------------------------------
    // Result checker: sampled at the falling edge, mid-way through the single
    // cycle in which done is high.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        frame_result_t got;
        frame_result_t want;
        if (rst_n && done === 1'b1) begin
            got = {pixel_value, out_byte, is_data, byte_valid, frame_last};
            if (expected_q.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end
            else begin
                want = expected_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "pix %b/%b byte %h/%h data %b/%b valid %b/%b last %b/%b (got/exp)",
                        got.pixel_value, want.pixel_value, got.out_byte, want.out_byte,
                        got.is_data, want.is_data, got.byte_valid, want.byte_valid,
                        got.frame_last, want.frame_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full mode: one whole frame (8 pages x 128 columns) at a random offset,
    // with writes and reads in a small area landing while the frame runs.
    task automatic test_full_frame();
        set_register(CFG_PARTIAL, 1'b0);
        set_register(CFG_COL_OFFSET, 7'($urandom_range(1, 126)));
        area_x = $urandom_range(0, 120);
        area_y = $urandom_range(0, 56);
        area_w = 7;
        area_h = 7;
        run_frame(6);
    endtask

    // Directed corners: empty frame, off-screen writes/reads, unused kind,
    // one-page frames at both screen edges with the largest offset.
    task automatic test_directed();
        set_register(CFG_COL_OFFSET, 7'd127);
        set_register(CFG_PARTIAL, 1'b1);
        run_frame(0);                       // flush whatever the last frame left dirty
        send_request(KIND_REFRESH, 8'd0, 8'd0, 1'b0);   // empty box
        send_request(KIND_WRITE, 8'd0, 8'd0, 1'b1);
        send_request(KIND_WRITE, 8'd1, 8'd7, 1'b1);
        send_request(KIND_WRITE, 8'd1, 8'd6, 1'b1);
        send_request(KIND_WRITE, 8'd1, 8'd6, 1'b0);
        send_request(KIND_WRITE, 8'd128, 8'd0, 1'b1);   // off screen: ignored
        send_request(KIND_WRITE, 8'd0, 8'd64, 1'b1);
        send_request(KIND_WRITE, 8'd255, 8'd255, 1'b1);
        send_request(KIND_READ, 8'd0, 8'd0, 1'b0);
        send_request(KIND_READ, 8'd1, 8'd7, 1'b1);
        send_request(KIND_READ, 8'd1, 8'd6, 1'b0);
        send_request(KIND_READ, 8'd128, 8'd0, 1'b0);    // off screen reads as 0
        send_request(KIND_READ, 8'd255, 8'd255, 1'b1);
        send_request(KIND_UNUSED, 8'd255, 8'd255, 1'b1);
        run_frame(0);                       // page 0, columns 0..1
        send_request(KIND_WRITE, 8'd127, 8'd63, 1'b1);
        send_request(KIND_WRITE, 8'd126, 8'd56, 1'b0);
        run_frame(0);                       // page 7, columns 126..127
    endtask

    // Partial mode: rounds of writes in a random small area, off-screen
    // noise and reads, then the dirty frame. Offsets move between rounds;
    // one round rewrites config in the middle of a frame.
    task automatic test_partial_random();
        logic [1:0] k;
        for (int rnd = 0; rnd < 8; rnd++) begin
            if (rnd % 4 == 0)
                set_register(CFG_COL_OFFSET, rnd == 0 ? 7'd0 :
                             rnd == 4 ? 7'd127 : 7'($urandom_range(0, 127)));
            area_x = $urandom_range(0, 127);
            area_y = $urandom_range(0, 63);
            area_w = $urandom_range(0, 11);
            area_h = $urandom_range(0, 11);
            if (rnd == 7 || $urandom_range(0, 5) != 0)
                repeat ($urandom_range(1, 6)) poke_area(1'b1);
            repeat ($urandom_range(0, 2)) begin
                k = 2'($urandom_range(0, 2));
                if (k == KIND_REFRESH)
                    k = KIND_UNUSED;
                send_request(k, 8'($urandom), 8'($urandom_range(64, 255)),
                             1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(0, 3)) poke_area(1'b0);
            if (rnd == 7) begin
                // mode is latched at frame start, the offset is not
                repeat (5) send_request(KIND_REFRESH, 8'($urandom), 8'($urandom), 1'b0);
                set_register(CFG_COL_OFFSET, 7'($urandom_range(0, 127)));
                set_register(CFG_PARTIAL, 1'b0);
                set_register(CFG_PARTIAL, 1'b1);
            end
            run_frame(0);
        end
    endtask

    initial begin
        foreach (shadow_fb[i])
            shadow_fb[i] = 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // the clearing pass after reset shows up as busy; requests just wait

        test_full_frame();
        test_directed();
        test_partial_random();

        wait_idle();
        repeat (8) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: page_framebuffer_refresh.f
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_ram.sv
hw/rtl/pfr_refresh.sv
hw/rtl/page_framebuffer_refresh.sv
verif/tb_top.sv
